@@ sv/obdb_pkg.sv @@
package obdb_pkg;

  localparam int unsigned MAX_ORDERS_DEF = 256;
  localparam int unsigned MAX_BINS_DEF   = 64;
  localparam int unsigned PRICE_BITS_DEF = 48;

  localparam int unsigned FIELD_PRICE_W  = 48;
  localparam int unsigned FIELD_VOL_W    = 32;
  localparam int unsigned OUT_VOL_W      = 40;
  localparam int unsigned ADDR_W         = 5;
  localparam int unsigned DATA_W         = 64;

  localparam logic [1:0] REG_TICK = 2'd0;
  localparam logic [1:0] REG_MIN  = 2'd1;
  localparam logic [1:0] REG_MAX  = 2'd2;

  localparam logic OP_EVENT  = 1'b0;
  localparam logic OP_COLUMN = 1'b1;

  localparam logic signed [63:0] VOL_MAX = 64'sd549755813887;
  localparam logic signed [63:0] VOL_MIN = -64'sd549755813888;

  typedef struct packed {
    logic               operation;
    logic [63:0]        order_key_high;
    logic [63:0]        order_key_low;
    logic               is_active;
    logic [47:0]        order_price;
    logic signed [31:0] order_volume;
  } in_t;

  typedef struct packed {
    logic [5:0]         bin_index;
    logic signed [39:0] bin_volume;
    logic               last_bin;
    logic               table_overflow;
  } out_t;

  typedef struct packed {
    logic [31:0] tick;
    logic [47:0] px_lo;
    logic [47:0] px_hi;
  } cfg_t;

  typedef struct packed {
    logic valid;
    in_t  item;
  } queue_head_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_EVT_WR,
    S_MIN_DIV,
    S_MAX_DIV,
    S_COUNT,
    S_ENT_RD,
    S_ENT_WAIT,
    S_ENT_DIV,
    S_BIN_RD,
    S_BIN_WR,
    S_OUT_RD,
    S_OUT_EMIT
  } state_t;

endpackage

@@ sv/order_book_depth_binning.sv @@
// Live order table with a price-binned depth column.
// Commands: start/busy; an item is taken when start is high and busy is low.
// busy rises only when the two-deep command queue is full.
// An order event (operation 0) reads and compares every table entry in turn
// (S_SCAN_RD, S_SCAN_CMP) and then writes.
// A column request (operation 1) runs two divisions for the range, then per
// live entry one bit-serial division of the price by the tick and, when the
// quotient falls in range, a bin read-modify-write; then one result follows
// per bin, each read and then emitted. Dead entries are skipped.
// All divisions use the one shared divider.
// Results: result_valid marks each transfer for one cycle, bins in
// ascending order, last_bin on the final one. The receiver cannot stall.
// Configuration: APB, 64-bit bus, registers at 0 (tick), 8 (min), 16 (max);
// write only while idle.
// Reset (rst, synchronous) empties the table and queue, clears the
// overflow flag and restores tick 1, min 0, max 62.
module order_book_depth_binning #(
  parameter int unsigned MAX_ORDERS = obdb_pkg::MAX_ORDERS_DEF,
  parameter int unsigned MAX_BINS   = obdb_pkg::MAX_BINS_DEF,
  parameter int unsigned PRICE_BITS = obdb_pkg::PRICE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  obdb_pkg::in_t                 req,
  output logic                          result_valid,
  output obdb_pkg::out_t                result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [obdb_pkg::ADDR_W-1:0]   paddr,
  input  logic [obdb_pkg::DATA_W-1:0]   pwdata,
  output logic [obdb_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  obdb_pkg::cfg_t        cfg;
  obdb_pkg::queue_head_t head;
  logic                  pop;
  logic                  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick  <= 32'd1;
      cfg.px_lo <= 48'd0;
      cfg.px_hi <= 48'd62;
    end else if (wr_en) begin
      unique case (paddr[4:3])
        obdb_pkg::REG_TICK: cfg.tick  <= pwdata[31:0];
        obdb_pkg::REG_MIN:  cfg.px_lo <= pwdata[47:0];
        obdb_pkg::REG_MAX:  cfg.px_hi <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      obdb_pkg::REG_TICK: prdata = 64'(cfg.tick);
      obdb_pkg::REG_MIN:  prdata = 64'(cfg.px_lo);
      obdb_pkg::REG_MAX:  prdata = 64'(cfg.px_hi);
      default:            prdata = '0;
    endcase
  end

  obdb_front u_front (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy),
    .pop(pop), .head(head)
  );

  obdb_back #(
    .MAX_ORDERS(MAX_ORDERS), .MAX_BINS(MAX_BINS), .PRICE_BITS(PRICE_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .head(head), .pop(pop),
    .result_valid(result_valid), .result(result)
  );

`ifndef SYNTHESIS
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result during reset");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last_bin) |=> !result_valid)
    else $error("result after last bin");
  a_bin_order: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last_bin) |-> ##2
    (result_valid && result.bin_index == 6'($past(result.bin_index, 2) + 6'd1)))
    else $error("bins out of order");
`endif

endmodule

@@ sv/obdb_ram.sv @@
module obdb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/obdb_divider.sv @@
module obdb_divider #(
  parameter int unsigned DW = 48
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [31:0]   divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic          rem_nz
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          running;
  logic [CW-1:0] cnt;
  logic [31:0]   rem;
  logic [DW-1:0] dvd;
  logic [32:0]   rem_sh;
  logic          take;

  assign rem_sh = {rem, dvd[DW-1]};
  assign take   = rem_sh >= {1'b0, divisor};
  assign rem_nz = rem != 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        cnt      <= CW'(DW);
        rem      <= '0;
        dvd      <= dividend;
        quotient <= '0;
      end else if (running) begin
        rem      <= take ? 32'(rem_sh - {1'b0, divisor}) : rem_sh[31:0];
        dvd      <= dvd << 1;
        quotient <= {quotient[DW-2:0], take};
        cnt      <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/obdb_front.sv @@
module obdb_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  obdb_pkg::in_t         req,
  output logic                  busy,
  input  logic                  pop,
  output obdb_pkg::queue_head_t head
);

  obdb_pkg::in_t slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  logic          take;

  assign busy       = count == 2'd2;
  assign push       = start && !busy;
  assign take       = pop && count != 2'd0;
  assign head.valid = count != 2'd0;
  assign head.item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (take) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(take);
    end
  end

endmodule

@@ sv/obdb_back.sv @@
module obdb_back #(
  parameter int unsigned MAX_ORDERS = obdb_pkg::MAX_ORDERS_DEF,
  parameter int unsigned MAX_BINS   = obdb_pkg::MAX_BINS_DEF,
  parameter int unsigned PRICE_BITS = obdb_pkg::PRICE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  obdb_pkg::cfg_t        cfg,
  input  obdb_pkg::queue_head_t head,
  output logic                  pop,
  output logic                  result_valid,
  output obdb_pkg::out_t        result
);

  localparam int unsigned AW  = $clog2(MAX_ORDERS);
  localparam int unsigned BW  = $clog2(MAX_BINS);
  localparam int unsigned NW  = $clog2(MAX_BINS + 1);
  localparam int unsigned DW  = (PRICE_BITS > 48) ? PRICE_BITS : 48;
  localparam int unsigned QW  = DW + 2;
  localparam int unsigned SW  = 32 + AW + 1;
  localparam int unsigned EW  = 128 + PRICE_BITS + 32;

  obdb_pkg::state_t state;
  obdb_pkg::state_t state_next;

  obdb_pkg::in_t    cur;
  logic [AW:0]      idx;
  logic             hit;
  logic [AW-1:0]    hit_slot;
  logic             free_ok;
  logic [AW-1:0]    free_slot;
  logic             overflow;
  logic [MAX_ORDERS-1:0] valid;
  logic [MAX_BINS-1:0]   bin_valid;
  logic [QW-1:0]    qmin;
  logic [QW-1:0]    qmax;
  logic [NW-1:0]    n_bins;
  logic signed [31:0] ent_vol;
  logic [BW-1:0]    bin_d;
  logic [BW-1:0]    bin_k;

  logic             e_we;
  logic [AW-1:0]    e_waddr;
  logic [EW-1:0]    e_wdata;
  logic [AW-1:0]    e_raddr;
  logic [EW-1:0]    e_rdata;
  logic             b_we;
  logic [BW-1:0]    b_waddr;
  logic [SW-1:0]    b_wdata;
  logic [BW-1:0]    b_raddr;
  logic [SW-1:0]    b_rdata;

  logic             d_start;
  logic [DW-1:0]    d_dividend;
  logic [31:0]      d_divisor;
  logic             d_done;
  logic [DW-1:0]    d_quo;
  logic             d_rem_nz;

  logic [63:0]        r_key_high;
  logic [63:0]        r_key_low;
  logic [PRICE_BITS-1:0] r_price;
  logic signed [31:0] r_vol;
  logic               key_match;
  logic [QW-1:0]      q_ent;
  logic [QW-1:0]      d_ent;
  logic               in_range;
  logic [QW-1:0]      n_full;
  logic               last_scan;
  logic signed [SW-1:0] old_sum;
  logic signed [63:0]   sum_ext;
  logic signed [39:0]   sum_sat;
  logic                 is_last;

  assign {r_key_high, r_key_low, r_price, r_vol} = e_rdata;
  assign key_match = valid[idx[AW-1:0]] && r_key_high == cur.order_key_high
                     && r_key_low == cur.order_key_low;
  assign last_scan = idx == (AW + 1)'(MAX_ORDERS - 1);
  assign d_divisor = (cfg.tick == 32'd0) ? 32'd1 : cfg.tick;

  assign q_ent    = QW'(d_quo) + QW'((ent_vol <= 0) && d_rem_nz);
  assign d_ent    = q_ent - qmin;
  assign in_range = (q_ent >= qmin) && (d_ent < QW'(n_bins));
  assign n_full   = qmax + QW'(2) - qmin;

  assign old_sum = bin_valid[b_raddr] ? $signed(b_rdata) : '0;
  assign sum_ext = 64'(old_sum);
  assign sum_sat = (sum_ext > obdb_pkg::VOL_MAX) ? 40'(obdb_pkg::VOL_MAX) :
                   (sum_ext < obdb_pkg::VOL_MIN) ? 40'(obdb_pkg::VOL_MIN) : 40'(sum_ext);
  assign is_last = NW'(bin_k) + NW'(1) == n_bins;

  obdb_ram #(.WIDTH(EW), .DEPTH(MAX_ORDERS)) u_entries (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  obdb_ram #(.WIDTH(SW), .DEPTH(MAX_BINS)) u_bins (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  obdb_divider #(.DW(DW)) u_div (
    .clk(clk), .rst(rst), .start(d_start), .dividend(d_dividend),
    .divisor(d_divisor), .done(d_done), .quotient(d_quo), .rem_nz(d_rem_nz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= obdb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    e_we       = 1'b0;
    e_waddr    = hit ? hit_slot : free_slot;
    e_wdata    = {cur.order_key_high, cur.order_key_low,
                  PRICE_BITS'(cur.order_price), cur.order_volume};
    e_raddr    = idx[AW-1:0];
    b_we       = 1'b0;
    b_waddr    = bin_d;
    b_wdata    = SW'(old_sum + SW'(ent_vol));
    b_raddr    = (state == obdb_pkg::S_OUT_RD || state == obdb_pkg::S_OUT_EMIT) ? bin_k : bin_d;
    d_start    = 1'b0;
    d_dividend = DW'(cfg.px_lo);
    unique case (state)
      obdb_pkg::S_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.item.operation == obdb_pkg::OP_COLUMN) begin
            d_start    = 1'b1;
            state_next = obdb_pkg::S_MIN_DIV;
          end else begin
            state_next = obdb_pkg::S_SCAN_RD;
          end
        end
      end
      obdb_pkg::S_SCAN_RD: state_next = obdb_pkg::S_SCAN_CMP;
      obdb_pkg::S_SCAN_CMP: begin
        state_next = last_scan ? obdb_pkg::S_EVT_WR : obdb_pkg::S_SCAN_RD;
      end
      obdb_pkg::S_EVT_WR: begin
        e_we       = cur.is_active && (hit || free_ok);
        state_next = obdb_pkg::S_IDLE;
      end
      obdb_pkg::S_MIN_DIV: begin
        d_dividend = DW'(cfg.px_hi);
        if (d_done) begin
          d_start    = 1'b1;
          state_next = obdb_pkg::S_MAX_DIV;
        end
      end
      obdb_pkg::S_MAX_DIV: begin
        if (d_done) begin
          state_next = obdb_pkg::S_COUNT;
        end
      end
      obdb_pkg::S_COUNT: state_next = obdb_pkg::S_ENT_RD;
      obdb_pkg::S_ENT_RD: begin
        if (idx == (AW + 1)'(MAX_ORDERS)) begin
          state_next = (n_bins == '0) ? obdb_pkg::S_IDLE : obdb_pkg::S_OUT_RD;
        end else if (valid[idx[AW-1:0]]) begin
          state_next = obdb_pkg::S_ENT_WAIT;
        end
      end
      obdb_pkg::S_ENT_WAIT: begin
        d_dividend = DW'(r_price);
        d_start    = 1'b1;
        state_next = obdb_pkg::S_ENT_DIV;
      end
      obdb_pkg::S_ENT_DIV: begin
        if (d_done) begin
          state_next = in_range ? obdb_pkg::S_BIN_RD : obdb_pkg::S_ENT_RD;
        end
      end
      obdb_pkg::S_BIN_RD: state_next = obdb_pkg::S_BIN_WR;
      obdb_pkg::S_BIN_WR: begin
        b_we       = 1'b1;
        state_next = obdb_pkg::S_ENT_RD;
      end
      obdb_pkg::S_OUT_RD: state_next = obdb_pkg::S_OUT_EMIT;
      obdb_pkg::S_OUT_EMIT: begin
        state_next = is_last ? obdb_pkg::S_IDLE : obdb_pkg::S_OUT_RD;
      end
      default: state_next = obdb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      bin_valid    <= '0;
      overflow     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        obdb_pkg::S_IDLE: begin
          cur     <= head.item;
          idx     <= '0;
          hit     <= 1'b0;
          free_ok <= 1'b0;
        end
        obdb_pkg::S_SCAN_CMP: begin
          if (key_match && !hit) begin
            hit      <= 1'b1;
            hit_slot <= idx[AW-1:0];
          end
          if (!valid[idx[AW-1:0]] && !free_ok) begin
            free_ok   <= 1'b1;
            free_slot <= idx[AW-1:0];
          end
          idx <= idx + (AW + 1)'(1);
        end
        obdb_pkg::S_EVT_WR: begin
          if (cur.is_active) begin
            if (hit) begin
              valid[hit_slot] <= 1'b1;
            end else if (free_ok) begin
              valid[free_slot] <= 1'b1;
            end else begin
              overflow <= 1'b1;
            end
          end else if (hit) begin
            valid[hit_slot] <= 1'b0;
          end
        end
        obdb_pkg::S_MIN_DIV: begin
          if (d_done) begin
            qmin <= QW'(d_quo);
          end
        end
        obdb_pkg::S_MAX_DIV: begin
          if (d_done) begin
            qmax <= QW'(d_quo) + QW'(d_rem_nz);
          end
        end
        obdb_pkg::S_COUNT: begin
          if (qmax + QW'(1) < qmin) begin
            n_bins <= '0;
          end else if (n_full > QW'(MAX_BINS)) begin
            n_bins <= NW'(MAX_BINS);
          end else begin
            n_bins <= NW'(n_full);
          end
          bin_valid <= '0;
          bin_k     <= '0;
          idx       <= '0;
        end
        obdb_pkg::S_ENT_RD: begin
          if (idx != (AW + 1)'(MAX_ORDERS) && !valid[idx[AW-1:0]]) begin
            idx <= idx + (AW + 1)'(1);
          end
        end
        obdb_pkg::S_ENT_WAIT: ent_vol <= r_vol;
        obdb_pkg::S_ENT_DIV: begin
          if (d_done) begin
            bin_d <= BW'(d_ent);
            if (!in_range) begin
              idx <= idx + (AW + 1)'(1);
            end
          end
        end
        obdb_pkg::S_BIN_WR: begin
          bin_valid[bin_d] <= 1'b1;
          idx              <= idx + (AW + 1)'(1);
        end
        obdb_pkg::S_OUT_EMIT: begin
          result_valid          <= 1'b1;
          result.bin_index      <= 6'(bin_k);
          result.bin_volume     <= sum_sat;
          result.last_bin       <= is_last;
          result.table_overflow <= overflow;
          bin_k                 <= bin_k + BW'(1);
        end
        default: ;
      endcase
    end
  end

endmodule
